### design/eur_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eur_pkg
// Shared types and constants for the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package eur_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Register widths
    localparam int TRIG_W  = 10;
    localparam int WAIT_W  = 16;
    localparam int LEVEL_W = 10;

    // Register reset values
    localparam logic [TRIG_W-1:0]  TRIG_TICKS_RST = 10'd10;
    localparam logic [WAIT_W-1:0]  WAIT_LIMIT_RST = 16'd30000;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL_RST = 10'd3;
    localparam logic [LEVEL_W-1:0] EMPTY_LEVEL_RST = 10'd10;

    // Echo width to centimeters: (width * 17841) >> 20, saturated
    localparam int               SCALE_MUL_W = 15;
    localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = 15'd17841;
    localparam int               SCALE_SHIFT = 20;
    localparam int               DIST_W      = 11;
    localparam logic [DIST_W-1:0] DIST_MAX   = 11'd2047;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIGGER_TICKS   = 4'd0,
        REG_ECHO_WAIT_LIMIT = 4'd1,
        REG_FULL_LEVEL_CM   = 4'd2,
        REG_EMPTY_LEVEL_CM  = 4'd3
    } cfg_idx_t;

    // Tank level classes
    typedef enum logic [1:0] {
        CLASS_FULL  = 2'd0,
        CLASS_SAFE  = 2'd1,
        CLASS_EMPTY = 2'd2
    } level_class_t;

    // Timing registers seen by the sequencer
    typedef struct packed {
        logic [TRIG_W-1:0] trigger_ticks;
        logic [WAIT_W-1:0] echo_wait_limit;
    } eur_timing_t;

    // Threshold registers seen by the classifier
    typedef struct packed {
        logic [LEVEL_W-1:0] full_level_cm;
        logic [LEVEL_W-1:0] empty_level_cm;
    } eur_thresh_t;

    // Per-beat status flags carried down the pipeline
    typedef struct packed {
        logic trigger_level;
        logic busy;
        logic done;
        logic timeout;
    } eur_flags_t;

endpackage

### design/eur_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eur_in_if
// Sample channel: one beat per microsecond tick.
// ----------------------------------------------------------------------------
interface eur_in_if;

    logic valid;
    logic ready;
    logic start_request;
    logic echo_level;

    modport source (output valid, output start_request, output echo_level, input ready);
    modport sink   (input valid, input start_request, input echo_level, output ready);

endinterface

### design/eur_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eur_out_if
// Result channel: one beat per accepted sample beat.
// ----------------------------------------------------------------------------
interface eur_out_if import eur_pkg::*;
();

    logic              valid;
    logic              ready;
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    logic [DIST_W-1:0] distance_cm;
    logic [1:0]        level_class;
    logic              timed_out;

    modport source (
        output valid, output trigger_level, output busy_res, output done_res,
        output distance_cm, output level_class, output timed_out, input ready
    );
    modport sink (
        input valid, input trigger_level, input busy_res, input done_res,
        input distance_cm, input level_class, input timed_out, output ready
    );

endinterface

### design/eur_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eur_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface eur_cfg_if import eur_pkg::*;
();

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

### design/eur_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eur_ctrl
// Measurement sequencer: trigger, echo wait and echo width count, advanced
// once per accepted sample beat. Feeds the first pipeline register.
// ----------------------------------------------------------------------------
module eur_ctrl import eur_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    eur_in_if.sink                sample,
    input  eur_timing_t           timing,
    input  logic                  s1_take,
    output logic                  s1_valid,
    output eur_flags_t            s1_flags,
    output logic [COUNT_BITS-1:0] s1_count
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT,
        PH_MEAS
    } phase_t;

    localparam int CMP_W = (COUNT_BITS > WAIT_W) ? COUNT_BITS : WAIT_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_inc;
    logic [CMP_W-1:0]      inc_ext;
    logic [COUNT_BITS-1:0] width_out;
    logic                  done;
    logic                  timeout;
    logic                  accept;

    logic                  s1_valid_reg;
    eur_flags_t            s1_flags_reg;
    logic [COUNT_BITS-1:0] s1_count_reg;

    // Sample beat taken whenever the first stage is free or draining
    assign sample.ready = !s1_valid_reg || s1_take;
    assign accept       = sample.valid && sample.ready;

    // Saturating tick counter
    assign count_inc = (count_reg != COUNT_MAX) ? count_reg + COUNT_BITS'(1) : count_reg;
    assign inc_ext   = CMP_W'(count_inc);

    // Phase transitions for one tick
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        width_out  = '0;
        done       = 1'b0;
        timeout    = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (sample.start_request)
                begin
                    phase_next = PH_TRIG;
                    count_next = '0;
                end
            end
            PH_TRIG:
            begin
                if (inc_ext >= CMP_W'(timing.trigger_ticks))
                begin
                    phase_next = PH_WAIT;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_WAIT:
            begin
                if (sample.echo_level)
                begin
                    phase_next = PH_MEAS;
                    count_next = COUNT_BITS'(1);
                end
                else if (inc_ext >= CMP_W'(timing.echo_wait_limit) || count_inc == COUNT_MAX)
                begin
                    // no echo: width 0 gives distance 0 downstream
                    phase_next = PH_IDLE;
                    count_next = '0;
                    done       = 1'b1;
                    timeout    = 1'b1;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_MEAS:
            begin
                if (sample.echo_level)
                begin
                    count_next = count_inc;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                    width_out  = count_reg;
                    done       = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                count_next = '0;
            end
        endcase
    end

    // State and first pipeline register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s1_flags_reg <= '0;
            s1_count_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg                  <= phase_next;
                count_reg                  <= count_next;
                s1_valid_reg               <= 1'b1;
                s1_flags_reg.trigger_level <= (phase_next == PH_TRIG);
                s1_flags_reg.busy          <= (phase_next != PH_IDLE);
                s1_flags_reg.done          <= done;
                s1_flags_reg.timeout       <= timeout;
                s1_count_reg               <= width_out;
            end
            else if (s1_take)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_flags = s1_flags_reg;
    assign s1_count = s1_count_reg;

endmodule

### design/eur_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eur_scale
// Scaling stage: multiplies the echo width by the centimeter factor and
// registers the product.
// ----------------------------------------------------------------------------
module eur_scale import eur_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s1_valid,
    input  eur_flags_t                          s1_flags,
    input  logic [COUNT_BITS-1:0]               s1_count,
    input  logic                                s2_take,
    output logic                                s1_take,
    output logic                                s2_valid,
    output eur_flags_t                          s2_flags,
    output logic [COUNT_BITS+SCALE_MUL_W-1:0]   s2_product
);

    localparam int PROD_W = COUNT_BITS + SCALE_MUL_W;

    logic              s2_valid_reg;
    eur_flags_t        s2_flags_reg;
    logic [PROD_W-1:0] s2_product_reg;
    logic [PROD_W-1:0] product;

    // Stage moves when the next one has room
    assign s1_take = s1_valid && (!s2_valid_reg || s2_take);

    // Width times scale factor
    assign product = PROD_W'(s1_count) * PROD_W'(SCALE_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg   <= 1'b0;
            s2_flags_reg   <= '0;
            s2_product_reg <= '0;
        end
        else
        begin
            if (s1_take)
            begin
                s2_valid_reg   <= 1'b1;
                s2_flags_reg   <= s1_flags;
                s2_product_reg <= product;
            end
            else if (s2_take)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    assign s2_valid   = s2_valid_reg;
    assign s2_flags   = s2_flags_reg;
    assign s2_product = s2_product_reg;

endmodule

### design/eur_class.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eur_class
// Result stage: scales the product down to centimeters, classes the level
// and holds the last measurement in the result register.
// ----------------------------------------------------------------------------
module eur_class import eur_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s2_valid,
    input  eur_flags_t                        s2_flags,
    input  logic [COUNT_BITS+SCALE_MUL_W-1:0] s2_product,
    input  eur_thresh_t                       thresh,
    output logic                              s2_take,
    eur_out_if.source                         result
);

    localparam int PROD_W = COUNT_BITS + SCALE_MUL_W;

    logic [PROD_W-1:0] shifted;
    logic [DIST_W-1:0] dist_cm;
    level_class_t      dist_class;

    logic              out_valid_reg;
    eur_flags_t        flags_reg;
    logic [DIST_W-1:0] distance_reg;
    level_class_t      class_reg;
    logic              timeout_reg;

    assign s2_take = s2_valid && (!out_valid_reg || result.ready);

    // Truncated centimeters, saturated to the field width
    assign shifted = s2_product >> SCALE_SHIFT;
    assign dist_cm = (shifted > PROD_W'(DIST_MAX)) ? DIST_MAX : shifted[DIST_W-1:0];

    // Full is tested before empty
    always_comb
    begin
        if (dist_cm <= DIST_W'(thresh.full_level_cm))
        begin
            dist_class = CLASS_FULL;
        end
        else if (dist_cm > DIST_W'(thresh.empty_level_cm))
        begin
            dist_class = CLASS_EMPTY;
        end
        else
        begin
            dist_class = CLASS_SAFE;
        end
    end

    // Result register; last measurement changes only on a done beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            distance_reg  <= '0;
            class_reg     <= CLASS_FULL;
            timeout_reg   <= 1'b0;
        end
        else
        begin
            if (s2_take)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= s2_flags;
                if (s2_flags.done)
                begin
                    distance_reg <= dist_cm;
                    class_reg    <= dist_class;
                    timeout_reg  <= s2_flags.timeout;
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.trigger_level = flags_reg.trigger_level;
    assign result.busy_res      = flags_reg.busy;
    assign result.done_res      = flags_reg.done;
    assign result.distance_cm   = distance_reg;
    assign result.level_class   = class_reg;
    assign result.timed_out     = timeout_reg;

endmodule

### design/ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps
// A sample beat passes through the sequencer register, the multiplier register
// and the result register, in that order.
// Throughput: one sample beat per cycle while no result beat is held; the result
// register and the two pipeline registers each take a new beat while the one after them drains.
// Reset: asynchronous, active low; idle phase, count and last result cleared,
// configuration registers back to their defaults.
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Ultrasonic range sensor front end: trigger pulse, echo timing, distance in
// centimeters and tank level class, one result beat per microsecond tick.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger import eur_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    eur_in_if.sink     sample,
    eur_out_if.source  result,
    eur_cfg_if.sink    cfg
);

    localparam int PROD_W = COUNT_BITS + SCALE_MUL_W;

    eur_timing_t           timing_reg;
    eur_thresh_t           thresh_reg;

    logic                  s1_valid;
    logic                  s1_take;
    eur_flags_t            s1_flags;
    logic [COUNT_BITS-1:0] s1_count;
    logic                  s2_valid;
    logic                  s2_take;
    eur_flags_t            s2_flags;
    logic [PROD_W-1:0]     s2_product;

    // Configuration registers; writes always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.trigger_ticks   <= TRIG_TICKS_RST;
            timing_reg.echo_wait_limit <= WAIT_LIMIT_RST;
            thresh_reg.full_level_cm   <= FULL_LEVEL_RST;
            thresh_reg.empty_level_cm  <= EMPTY_LEVEL_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_TRIGGER_TICKS:   timing_reg.trigger_ticks   <= cfg.data[TRIG_W-1:0];
                REG_ECHO_WAIT_LIMIT: timing_reg.echo_wait_limit <= cfg.data[WAIT_W-1:0];
                REG_FULL_LEVEL_CM:   thresh_reg.full_level_cm   <= cfg.data[LEVEL_W-1:0];
                REG_EMPTY_LEVEL_CM:  thresh_reg.empty_level_cm  <= cfg.data[LEVEL_W-1:0];
                default:             ;
            endcase
        end
    end

    // Sequencer
    eur_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample),
        .timing   (timing_reg),
        .s1_take  (s1_take),
        .s1_valid (s1_valid),
        .s1_flags (s1_flags),
        .s1_count (s1_count)
    );

    // Width to centimeters
    eur_scale #(
        .COUNT_BITS (COUNT_BITS)
    ) u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid),
        .s1_flags   (s1_flags),
        .s1_count   (s1_count),
        .s2_take    (s2_take),
        .s1_take    (s1_take),
        .s2_valid   (s2_valid),
        .s2_flags   (s2_flags),
        .s2_product (s2_product)
    );

    // Classifier and result register
    eur_class #(
        .COUNT_BITS (COUNT_BITS)
    ) u_class (
        .clk        (clk),
        .rst_n      (rst_n),
        .s2_valid   (s2_valid),
        .s2_flags   (s2_flags),
        .s2_product (s2_product),
        .thresh     (thresh_reg),
        .s2_take    (s2_take),
        .result     (result)
    );

    // A stalled sample channel means a result beat is being held
    a_stall_from_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (result.valid && !result.ready)
    ) else $error("sample channel stalled with no held result");

    // A completed measurement leaves the block idle
    a_done_not_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && result.done_res) |-> (!result.busy_res && !result.trigger_level)
    ) else $error("done beat reports busy");

    // Trigger only during a measurement
    a_trigger_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && result.trigger_level) |-> result.busy_res
    ) else $error("trigger high while idle");

    // A timeout always reports distance zero
    a_timeout_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && result.timed_out) |-> (result.distance_cm == '0)
    ) else $error("timeout with nonzero distance");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ultrasonic echo ranger. Drives microsecond
// sample beats built as trigger/wait/echo sequences plus noise, predicts
// every result beat in a scoreboard and compares each field in order.
// Random stalls on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    import eur_pkg::*;

    localparam int          CNT_W      = 16;
    localparam int unsigned CYCLE_LIMIT = 20_000;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    // Index that maps to no register
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

    typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_WAIT, PH_MEAS} seq_phase_t;

    typedef struct packed {
        logic              trigger_level;
        logic              busy;
        logic              done;
        logic [DIST_W-1:0] distance;
        logic [1:0]        level;
        logic              timeout;
    } range_beat_t;

    // ------------------------------------------------------------------------
    // Scoreboard: ranger predictor plus queue of predicted result beats
    // ------------------------------------------------------------------------
    class range_scoreboard;
        logic [TRIG_W-1:0]  trig_ticks  = TRIG_TICKS_RST;
        logic [WAIT_W-1:0]  wait_limit  = WAIT_LIMIT_RST;
        logic [LEVEL_W-1:0] full_cm     = FULL_LEVEL_RST;
        logic [LEVEL_W-1:0] empty_cm    = EMPTY_LEVEL_RST;

        seq_phase_t         seq_phase   = PH_IDLE;
        logic [CNT_W-1:0]   tick_cnt    = '0;
        logic [DIST_W-1:0]  last_dist   = '0;
        level_class_t       last_level  = CLASS_FULL;
        logic               last_tmo    = 1'b0;

        range_beat_t        predicted_beats[$];
        int                 errors      = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TRIGGER_TICKS:   trig_ticks = data[TRIG_W-1:0];
                REG_ECHO_WAIT_LIMIT: wait_limit = data[WAIT_W-1:0];
                REG_FULL_LEVEL_CM:   full_cm    = data[LEVEL_W-1:0];
                REG_EMPTY_LEVEL_CM:  empty_cm   = data[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        // Store a finished measurement; full is tested before empty
        function void close_out(logic [DIST_W-1:0] range_cm, logic tmo);
            last_dist = range_cm;
            if (range_cm <= DIST_W'(full_cm))
                last_level = CLASS_FULL;
            else if (range_cm > DIST_W'(empty_cm))
                last_level = CLASS_EMPTY;
            else
                last_level = CLASS_SAFE;
            last_tmo  = tmo;
            seq_phase = PH_IDLE;
            tick_cnt  = '0;
        endfunction

        function void note_sample(logic start, logic echo);
            range_beat_t     beat;
            logic            fin;
            longint unsigned cm_wide;
            fin = 1'b0;
            case (seq_phase)
                PH_IDLE:
                begin
                    if (start)
                    begin
                        seq_phase = PH_TRIG;
                        tick_cnt  = '0;
                    end
                end
                PH_TRIG:
                begin
                    if (tick_cnt < CNT_MAX) tick_cnt++;
                    if (tick_cnt >= CNT_W'(trig_ticks))
                    begin
                        seq_phase = PH_WAIT;
                        tick_cnt  = '0;
                    end
                end
                PH_WAIT:
                begin
                    if (echo)
                    begin
                        seq_phase = PH_MEAS;
                        tick_cnt  = CNT_W'(1);
                    end
                    else
                    begin
                        if (tick_cnt < CNT_MAX) tick_cnt++;
                        if (tick_cnt >= wait_limit || tick_cnt >= CNT_MAX)
                        begin
                            close_out('0, 1'b1);
                            fin = 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (echo)
                    begin
                        if (tick_cnt < CNT_MAX) tick_cnt++;
                    end
                    else
                    begin
                        // Echo width to centimeters, round trip at 340.29 m/s
                        cm_wide = (64'(tick_cnt) * 64'(SCALE_MUL)) >> SCALE_SHIFT;
                        if (cm_wide > 64'(DIST_MAX)) cm_wide = 64'(DIST_MAX);
                        close_out(cm_wide[DIST_W-1:0], 1'b0);
                        fin = 1'b1;
                    end
                end
            endcase
            beat.trigger_level = (seq_phase == PH_TRIG);
            beat.busy          = (seq_phase != PH_IDLE);
            beat.done          = fin;
            beat.distance      = last_dist;
            beat.level         = last_level;
            beat.timeout       = last_tmo;
            predicted_beats.push_back(beat);
        endfunction

        function void compare_field(string fname, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0d got %0d", $time, fname, want, got);
                errors++;
            end
        endfunction

        function void check_result(range_beat_t got);
            range_beat_t want;
            if (predicted_beats.size() == 0)
            begin
                $display("%0t: result beat with nothing predicted, expected none got %h",
                         $time, got);
                errors++;
                return;
            end
            want = predicted_beats.pop_front();
            compare_field("trigger_level", 16'(want.trigger_level), 16'(got.trigger_level));
            compare_field("busy_res",      16'(want.busy),          16'(got.busy));
            compare_field("done_res",      16'(want.done),          16'(got.done));
            compare_field("distance_cm",   16'(want.distance),      16'(got.distance));
            compare_field("level_class",   16'(want.level),         16'(got.level));
            compare_field("timed_out",     16'(want.timeout),       16'(got.timeout));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, DUT
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned cycle_cnt = 0;
    int unsigned result_beats = 0;
    logic        calm;

    range_scoreboard sb = new();

    eur_in_if  sample_if ();
    eur_out_if result_if ();
    eur_cfg_if cfg_if ();

    ultrasonic_echo_ranger #(
        .COUNT_BITS (CNT_W)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // No random idling inside this window
    assign calm = (cycle_cnt >= 100) && (cycle_cnt < 260);

    // Cycle count and run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("** ultrasonic_echo_ranger: FAILED **");
            $finish;
        end
    end

    // Monitor: accepted beats on all three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_if.valid && sample_if.ready)
                sb.note_sample(sample_if.start_request, sample_if.echo_level);
            if (result_if.valid && result_if.ready)
            begin
                result_beats <= result_beats + 1;
                sb.check_result({result_if.trigger_level, result_if.busy_res,
                                 result_if.done_res, result_if.distance_cm,
                                 result_if.level_class, result_if.timed_out});
            end
            if (cfg_if.valid && cfg_if.ready)
                sb.write_reg(cfg_if.index, cfg_if.data);
        end
    end

    // Result sink: random stalls and one long hold-off to back up the pipe
    initial
    begin : result_sink
        bit held;
        held = 1'b0;
        result_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && result_beats >= 200)
            begin
                held = 1'b1;
                result_if.ready <= 1'b0;
                repeat (100) @(posedge clk);
            end
            else
            begin
                result_if.ready <= calm || ($urandom_range(0, 99) >= 10);
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    task automatic send_tick(input logic start, input logic echo);
        while (!calm && $urandom_range(0, 99) < 10)
        begin
            sample_if.valid <= 1'b0;
            @(posedge clk);
        end
        sample_if.valid         <= 1'b1;
        sample_if.start_request <= start;
        sample_if.echo_level    <= echo;
        do @(posedge clk); while (!sample_if.ready);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input int trig, input int lim, input int full, input int empty);
        cfg_write(REG_TRIGGER_TICKS,   CFG_DATA_W'(trig));
        cfg_write(REG_ECHO_WAIT_LIMIT, CFG_DATA_W'(lim));
        cfg_write(REG_FULL_LEVEL_CM,   CFG_DATA_W'(full));
        cfg_write(REG_EMPTY_LEVEL_CM,  CFG_DATA_W'(empty));
    endtask

    // Stop offering and wait until every predicted beat has come back
    task automatic drain();
        sample_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.predicted_beats.size() != 0) @(posedge clk);
    endtask

    // One measurement: start, trigger, echo after delay_ticks lasting width ticks.
    // A delay at or past the wait limit runs into the timeout instead.
    // Start requests while busy are sprinkled in and must be ignored.
    task automatic run_measure(input int delay_ticks, input int width);
        int trig_eff;
        int lim_eff;
        trig_eff = (sb.trig_ticks == 0) ? 1 : int'(sb.trig_ticks);
        lim_eff  = (sb.wait_limit == 0) ? 1 : int'(sb.wait_limit);
        send_tick(1'b1, 1'($urandom_range(0, 1)));
        repeat (trig_eff) send_tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
        if (delay_ticks >= lim_eff)
            repeat (lim_eff) send_tick($urandom_range(0, 7) == 0, 1'b0);
        else
        begin
            repeat (delay_ticks) send_tick($urandom_range(0, 7) == 0, 1'b0);
            repeat (width) send_tick($urandom_range(0, 7) == 0, 1'b1);
            send_tick($urandom_range(0, 7) == 0, 1'b0);
        end
        // idle ticks with echo noise
        repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : main
        int   trig_eff;
        int   lim_eff;
        logic lvl;

        rst_n                   <= 1'b0;
        sample_if.valid         <= 1'b0;
        sample_if.start_request <= 1'b0;
        sample_if.echo_level    <= 1'b0;
        cfg_if.valid            <= 1'b0;
        cfg_if.index            <= '0;
        cfg_if.data             <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: short echo gives distance 0
        repeat (4) send_tick(1'b0, 1'($urandom_range(0, 1)));
        run_measure(0, 1);
        drain();

        // Short wait limit: timeout, then the 0/1 cm edge with empty above 0 cm
        set_regs(2, 3, 0, 0);
        run_measure(3, 1);
        run_measure(0, 58);
        run_measure(1, 59);
        drain();

        // Zero trigger and zero wait limit, overlapping thresholds
        set_regs(0, 0, 1023, 0);
        run_measure(0, 5);
        run_measure(1, 1);
        drain();

        // Masked trigger write, write to an unused index, full/safe edge at 1 cm
        cfg_write(REG_UNUSED, 16'hFFFF);
        set_regs(16'h0403, 4, 1, 2);
        run_measure(0, 60);
        run_measure(2, 118);
        drain();

        // Random settings, short measurements, then free-running noise
        set_regs($urandom_range(0, 4), $urandom_range(0, 6),
                 $urandom_range(0, 2), $urandom_range(0, 3));
        repeat (3)
            run_measure($urandom_range(0, sb.wait_limit + 2), $urandom_range(1, 8));
        lvl = 1'b0;
        repeat (20)
        begin
            if ($urandom_range(0, 3) == 0) lvl = ~lvl;
            send_tick($urandom_range(0, 9) == 0, lvl);
        end
        // flush any measurement the noise left open
        trig_eff = (sb.trig_ticks == 0) ? 1 : int'(sb.trig_ticks);
        lim_eff  = (sb.wait_limit == 0) ? 1 : int'(sb.wait_limit);
        repeat (trig_eff + lim_eff + 2) send_tick(1'b0, 1'b0);
        drain();

        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("** ultrasonic_echo_ranger: PASSED **");
        else
            $display("** ultrasonic_echo_ranger: FAILED **");
        $finish;
    end

endmodule

### files.f
design/eur_pkg.sv
design/eur_in_if.sv
design/eur_out_if.sv
design/eur_cfg_if.sv
design/eur_ctrl.sv
design/eur_scale.sv
design/eur_class.sv
design/ultrasonic_echo_ranger.sv
tb/tb_top.sv
